/* rtl/owbm_pkg.sv */
package owbm_pkg;

  localparam int unsigned TimeW = 10;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_RST_LOW     = 3'd1,
    PH_RST_WAIT    = 3'd2,
    PH_RST_RECOVER = 3'd3,
    PH_SLOT_LOW    = 3'd4,
    PH_SLOT_SAMPLE = 3'd5,
    PH_SLOT_REST   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_RECOVER = 3'd2,
    REG_SLOT          = 3'd3,
    REG_SLOT_START    = 3'd4
  } cfg_idx_e;

  localparam logic [9:0] ResetLowDefault     = 10'd480;
  localparam logic [7:0] PresenceWaitDefault = 8'd80;
  localparam logic [9:0] ResetRecoverDefault = 10'd400;
  localparam logic [7:0] SlotDefault         = 8'd50;
  localparam logic [3:0] SlotStartDefault    = 4'd1;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] presence_wait_time;
    logic [9:0] reset_recover_time;
    logic [7:0] slot_time;
    logic [3:0] slot_start_time;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
  } res_t;

  // a programmed zero behaves as one
  function automatic logic [TimeW-1:0] at_least_one(input logic [TimeW-1:0] v);
    return (v == '0) ? TimeW'(1) : v;
  endfunction

endpackage

/* rtl/owbm_ifs.sv */
interface owbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       line_level;
  logic [7:0] write_byte;

  modport source (output valid, kind, line_level, write_byte, input ready);
  modport sink   (input valid, kind, line_level, write_byte, output ready);
endinterface

interface owbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_byte;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_byte,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte,
                  output ready);
endinterface

/* rtl/owbm_cfg_regs.sv */
module owbm_cfg_regs import owbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  input  logic [2:0] wr_index_i,
  input  logic [9:0] wr_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (cfg_idx_e'(wr_index_i))
        REG_RESET_LOW:     cfg_d.reset_low_time     = wr_data_i;
        REG_PRESENCE_WAIT: cfg_d.presence_wait_time = wr_data_i[7:0];
        REG_RESET_RECOVER: cfg_d.reset_recover_time = wr_data_i;
        REG_SLOT:          cfg_d.slot_time          = wr_data_i[7:0];
        REG_SLOT_START:    cfg_d.slot_start_time    = wr_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time     <= ResetLowDefault;
      cfg_q.presence_wait_time <= PresenceWaitDefault;
      cfg_q.reset_recover_time <= ResetRecoverDefault;
      cfg_q.slot_time          <= SlotDefault;
      cfg_q.slot_start_time    <= SlotStartDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/owbm_engine.sv */
module owbm_engine import owbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [1:0] kind_i,
  input  logic       line_level_i,
  input  logic [7:0] write_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] time_left_q, time_left_d;
  logic [2:0]       bit_count_q, bit_count_d;
  logic [7:0]       shift_out_q, shift_out_d;
  logic [7:0]       shift_in_q, shift_in_d;
  logic             presence_q, presence_d;
  kind_e            cmd_kind_q, cmd_kind_d;

  logic             last;
  logic             write0;
  logic             end_slot;
  logic             start_slot;
  logic             done;
  logic [TimeW-1:0] rel;

  always_comb begin
    phase_d     = phase_q;
    time_left_d = time_left_q;
    bit_count_d = bit_count_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    presence_d  = presence_q;
    cmd_kind_d  = cmd_kind_q;
    done        = 1'b0;
    end_slot    = 1'b0;
    start_slot  = 1'b0;
    last        = (time_left_q <= TimeW'(1));
    write0      = (cmd_kind_q == KIND_WRITE) && !shift_out_q[0];
    rel         = at_least_one(write0 ? TimeW'(cfg_i.slot_start_time)
                                      : TimeW'(cfg_i.slot_time));

    if (kind_e'(kind_i) == KIND_TICK) begin
      if (phase_q != PH_IDLE) begin
        if (!last && phase_q != PH_SLOT_SAMPLE) time_left_d = time_left_q - TimeW'(1);
        case (phase_q)
          PH_RST_LOW: begin
            if (last) begin
              phase_d     = PH_RST_WAIT;
              time_left_d = at_least_one(TimeW'(cfg_i.presence_wait_time));
            end
          end
          PH_RST_WAIT: begin
            if (last) begin
              presence_d  = !line_level_i;
              phase_d     = PH_RST_RECOVER;
              time_left_d = at_least_one(cfg_i.reset_recover_time);
            end
          end
          PH_RST_RECOVER: begin
            if (last) begin
              phase_d     = PH_IDLE;
              time_left_d = '0;
              done        = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (last) phase_d = PH_SLOT_SAMPLE;
          end
          PH_SLOT_SAMPLE: begin
            if (cmd_kind_q == KIND_READ) shift_out_d = {line_level_i, shift_out_q[7:1]};
            if (rel <= TimeW'(1)) begin
              end_slot = 1'b1;
            end else begin
              time_left_d = rel - TimeW'(1);
              phase_d     = PH_SLOT_REST;
            end
          end
          PH_SLOT_REST: begin
            if (last) end_slot = 1'b1;
          end
          default: begin
            phase_d     = PH_IDLE;
            time_left_d = '0;
          end
        endcase

        if (end_slot) begin
          if (cmd_kind_q == KIND_WRITE) shift_out_d = {1'b0, shift_out_d[7:1]};
          if (bit_count_q == 3'd7) begin
            bit_count_d = '0;
            if (cmd_kind_q == KIND_READ) shift_in_d = shift_out_d;
            phase_d     = PH_IDLE;
            time_left_d = '0;
            done        = 1'b1;
          end else begin
            bit_count_d = bit_count_q + 3'd1;
            start_slot  = 1'b1;
          end
        end
      end
    end else if (phase_q == PH_IDLE) begin
      cmd_kind_d = kind_e'(kind_i);
      if (kind_e'(kind_i) == KIND_RESET) begin
        phase_d     = PH_RST_LOW;
        time_left_d = at_least_one(cfg_i.reset_low_time);
      end else begin
        bit_count_d = '0;
        shift_out_d = (kind_e'(kind_i) == KIND_WRITE) ? write_byte_i : 8'h00;
        start_slot  = 1'b1;
      end
    end

    // write-0 slots hold the line low for the long part
    if (start_slot) begin
      phase_d     = PH_SLOT_LOW;
      time_left_d = ((cmd_kind_d == KIND_WRITE) && !shift_out_d[0])
                  ? at_least_one(TimeW'(cfg_i.slot_time))
                  : at_least_one(TimeW'(cfg_i.slot_start_time));
    end

    res_o.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW);
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.presence  = presence_d;
    res_o.read_byte = shift_in_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      time_left_q <= '0;
      bit_count_q <= '0;
      shift_out_q <= '0;
      shift_in_q  <= '0;
      presence_q  <= 1'b0;
      cmd_kind_q  <= KIND_TICK;
    end else if (en_i) begin
      phase_q     <= phase_d;
      time_left_q <= time_left_d;
      bit_count_q <= bit_count_d;
      shift_out_q <= shift_out_d;
      shift_in_q  <= shift_in_d;
      presence_q  <= presence_d;
      cmd_kind_q  <= cmd_kind_d;
    end
  end

  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> time_left_q == '0)
    else $error("timer not cleared while idle");

  a_idle_bits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bit_count_q == '0)
    else $error("bit counter not cleared while idle");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && done |=> phase_q == PH_IDLE)
    else $error("command completed but engine not idle");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(phase_q) && $stable(time_left_q))
    else $error("state moved without a request");

endmodule

/* rtl/one_wire_bus_master_top.sv */
// 1-Wire bus master. Every request on cmd_i is either a one-microsecond tick carrying the
// sampled line level, or a reset / write-byte / read-byte command (ignored unless idle).
// Each request yields exactly one result on res_o: line drive (open drain), busy, a done
// pulse, last presence and last read byte. Requests are taken at one per cycle unless
// res_o stalls; each passes an input register, one state update and a result register.
// The user must write timing registers on cfg_i only while idle (not enforced).
module one_wire_bus_master_top import owbm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  owbm_cmd_if.sink      cmd_i,
  owbm_cfg_if.sink      cfg_i,
  owbm_res_if.source    res_o
);

  logic       in_full_q;
  logic [1:0] in_kind_q;
  logic       in_line_q;
  logic [7:0] in_wbyte_q;
  logic       out_valid_q;
  res_t       out_q;
  res_t       res;
  cfg_t       cfg;
  logic       advance;

  assign advance     = in_full_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_full_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_full_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_kind_q  <= cmd_i.kind;
      in_line_q  <= cmd_i.line_level;
      in_wbyte_q <= cmd_i.write_byte;
    end
  end

  owbm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  owbm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .kind_i       (in_kind_q),
    .line_level_i (in_line_q),
    .write_byte_i (in_wbyte_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.drive_low = out_q.drive_low;
  assign res_o.busy_res  = out_q.busy_res;
  assign res_o.done_res  = out_q.done_res;
  assign res_o.presence  = out_q.presence;
  assign res_o.read_byte = out_q.read_byte;

endmodule

/* tb/sv/one_wire_bus_master_top_tb.sv */
`timescale 1ns / 100ps

module one_wire_bus_master_top_tb;
  import owbm_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic       line_level;
    logic [7:0] write_byte;
  } bus_req_t;

  typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  owbm_cmd_if cmd_if ();
  owbm_cfg_if cfg_if ();
  owbm_res_if res_if ();

  one_wire_bus_master_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  bus_req_t    pending_reqs[$];
  res_t        due_results[$];
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatches    = 0;
  cfg_t        plan;

  // shadow of the bus master
  cfg_t       bus_cfg;
  phase_e     bus_phase;
  logic [9:0] time_left;
  logic [2:0] bit_count;
  logic [7:0] shift_out;
  logic [7:0] shift_in;
  logic       presence_seen;
  kind_e      active_kind;

  function automatic logic [9:0] floor_one(logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic zero_slot();
    return active_kind == KIND_WRITE && !shift_out[0];
  endfunction

  function automatic void open_slot();
    time_left = floor_one(zero_slot() ? {2'b00, bus_cfg.slot_time}
                                      : {6'b000000, bus_cfg.slot_start_time});
    bus_phase = PH_SLOT_LOW;
  endfunction

  function automatic logic close_slot();
    if (active_kind == KIND_WRITE) shift_out = shift_out >> 1;
    if (bit_count == 3'd7) begin
      bit_count = 3'd0;
      if (active_kind == KIND_READ) shift_in = shift_out;
      bus_phase = PH_IDLE;
      time_left = 10'd0;
      return 1'b1;
    end
    bit_count = bit_count + 3'd1;
    open_slot();
    return 1'b0;
  endfunction

  function automatic logic bus_tick(logic line);
    logic       last;
    logic       fin;
    logic [9:0] rel;
    fin  = 1'b0;
    last = time_left <= 10'd1;
    if (!last && bus_phase != PH_SLOT_SAMPLE) time_left = time_left - 10'd1;
    case (bus_phase)
      PH_RST_LOW: if (last) begin
        bus_phase = PH_RST_WAIT;
        time_left = floor_one({2'b00, bus_cfg.presence_wait_time});
      end
      PH_RST_WAIT: if (last) begin
        presence_seen = !line;
        bus_phase     = PH_RST_RECOVER;
        time_left     = floor_one(bus_cfg.reset_recover_time);
      end
      PH_RST_RECOVER: if (last) begin
        bus_phase = PH_IDLE;
        time_left = 10'd0;
        fin       = 1'b1;
      end
      PH_SLOT_LOW: if (last) bus_phase = PH_SLOT_SAMPLE;
      PH_SLOT_SAMPLE: begin
        // first released tick: read slots latch the line here
        rel = floor_one(zero_slot() ? {6'b000000, bus_cfg.slot_start_time}
                                    : {2'b00, bus_cfg.slot_time});
        if (active_kind == KIND_READ) shift_out = {line, shift_out[7:1]};
        if (rel <= 10'd1) begin
          fin = close_slot();
        end else begin
          time_left = rel - 10'd1;
          bus_phase = PH_SLOT_REST;
        end
      end
      PH_SLOT_REST: if (last) fin = close_slot();
      default: begin
        bus_phase = PH_IDLE;
        time_left = 10'd0;
      end
    endcase
    return fin;
  endfunction

  function automatic res_t next_bus_result(bus_req_t r);
    res_t o;
    logic fin;
    fin = 1'b0;
    if (r.kind == KIND_TICK) begin
      if (bus_phase != PH_IDLE) fin = bus_tick(r.line_level);
    end else if (bus_phase == PH_IDLE) begin
      // commands while busy are dropped
      active_kind = r.kind;
      if (r.kind == KIND_RESET) begin
        bus_phase = PH_RST_LOW;
        time_left = floor_one(bus_cfg.reset_low_time);
      end else begin
        bit_count = 3'd0;
        shift_out = (r.kind == KIND_WRITE) ? r.write_byte : 8'h00;
        open_slot();
      end
    end
    o.drive_low = bus_phase == PH_RST_LOW || bus_phase == PH_SLOT_LOW;
    o.busy_res  = bus_phase != PH_IDLE;
    o.done_res  = fin;
    o.presence  = presence_seen;
    o.read_byte = shift_in;
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      bus_cfg       <= '{ResetLowDefault, PresenceWaitDefault, ResetRecoverDefault,
                         SlotDefault, SlotStartDefault};
      bus_phase     <= PH_IDLE;
      time_left     <= '0;
      bit_count     <= '0;
      shift_out     <= '0;
      shift_in      <= '0;
      presence_seen <= 1'b0;
      active_kind   <= KIND_TICK;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_RESET_LOW:     bus_cfg.reset_low_time     = cfg_if.data;
          REG_PRESENCE_WAIT: bus_cfg.presence_wait_time = cfg_if.data[7:0];
          REG_RESET_RECOVER: bus_cfg.reset_recover_time = cfg_if.data;
          REG_SLOT:          bus_cfg.slot_time          = cfg_if.data[7:0];
          REG_SLOT_START:    bus_cfg.slot_start_time    = cfg_if.data[3:0];
          default: ;
        endcase
      end
      if (cmd_if.valid && cmd_if.ready)
        due_results.push_back(next_bus_result('{kind_e'(cmd_if.kind), cmd_if.line_level,
                                                cmd_if.write_byte}));
    end
  end

  // request driver
  always @(posedge clk_i) begin
    bus_req_t r;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        r = pending_reqs.pop_front();
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= r.kind;
        cmd_if.line_level <= r.line_level;
        cmd_if.write_byte <= r.write_byte;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    res_t want;
    res_if.ready <= $urandom_range(99) >= sink_stall_pct;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected result, expected none, actual drive=%0b busy=%0b", $time,
                   res_if.drive_low, res_if.busy_res);
      end else begin
        want = due_results.pop_front();
        check_field("drive_low", want.drive_low, res_if.drive_low);
        check_field("busy_res",  want.busy_res,  res_if.busy_res);
        check_field("done_res",  want.done_res,  res_if.done_res);
        check_field("presence",  want.presence,  res_if.presence);
        check_field("read_byte", want.read_byte, res_if.read_byte);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [9:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // unused upper data bits get junk, the block must drop them
  task automatic program_timing(cfg_t c);
    plan = c;
    write_reg(REG_RESET_LOW, c.reset_low_time);
    write_reg(REG_PRESENCE_WAIT, {2'($urandom_range(3)), c.presence_wait_time});
    write_reg(REG_RESET_RECOVER, c.reset_recover_time);
    write_reg(REG_SLOT, {2'($urandom_range(3)), c.slot_time});
    write_reg(REG_SLOT_START, {6'($urandom_range(63)), c.slot_start_time});
  endtask

  function automatic int unsigned busy_ticks(kind_e k);
    int unsigned a, b, c;
    if (k == KIND_RESET) begin
      a = floor_one(plan.reset_low_time);
      b = floor_one({2'b00, plan.presence_wait_time});
      c = floor_one(plan.reset_recover_time);
      return a + b + c;
    end
    a = floor_one({2'b00, plan.slot_time});
    b = floor_one({6'b000000, plan.slot_start_time});
    return 8 * (a + b);
  endfunction

  task automatic queue_req(kind_e k, logic line, logic [7:0] wb);
    pending_reqs.push_back('{k, line, wb});
  endtask

  task automatic queue_ticks(int unsigned n, line_mode_e mode, bit noisy);
    logic line;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(99) < 4)
        queue_req(kind_e'($urandom_range(1, 3)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
      line = (mode == LINE_RANDOM) ? 1'($urandom_range(1)) : (mode == LINE_HIGH);
      queue_req(KIND_TICK, line, 8'($urandom_range(255)));
    end
  endtask

  task automatic queue_command(kind_e k, logic [7:0] wb, line_mode_e mode);
    queue_req(k, 1'($urandom_range(1)), wb);
    queue_ticks(busy_ticks(k), mode, 1'b0);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || cmd_if.valid || due_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned p);
    case (p % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
      default: begin src_idle_pct = 37; sink_stall_pct = 37; end
    endcase
  endtask

  initial begin
    cfg_t        c;
    kind_e       k;
    int unsigned n;
    int unsigned phase_reqs;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.kind       = KIND_TICK;
    cmd_if.line_level = 1'b1;
    cmd_if.write_byte = 8'h00;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_RESET_LOW;
    cfg_if.data       = '0;
    res_if.ready      = 1'b0;
    plan = '{ResetLowDefault, PresenceWaitDefault, ResetRecoverDefault,
             SlotDefault, SlotStartDefault};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // slot timing registers still at their reset values
    set_idling(0);
    queue_command(KIND_READ, 8'h00, LINE_RANDOM);
    drain();

    // directed: every programmed time zero, which must behave as one
    set_idling(1);
    program_timing('0);
    queue_req(KIND_TICK, 1'b0, 8'hFF);
    queue_req(KIND_TICK, 1'b1, 8'h00);
    queue_command(KIND_RESET, 8'h00, LINE_LOW);
    queue_command(KIND_RESET, 8'hFF, LINE_HIGH);
    queue_req(KIND_WRITE, 1'b0, 8'hFF);
    queue_ticks(3, LINE_HIGH, 1'b0);
    queue_req(KIND_READ, 1'b1, 8'h00);
    queue_req(KIND_RESET, 1'b0, 8'h55);
    queue_ticks(busy_ticks(KIND_WRITE) - 3, LINE_HIGH, 1'b0);
    queue_command(KIND_WRITE, 8'h00, LINE_LOW);
    queue_command(KIND_READ, 8'h00, LINE_HIGH);
    queue_command(KIND_READ, 8'hFF, LINE_LOW);
    drain();

    for (int unsigned p = 2; p < 8; p++) begin
      set_idling(p);
      c = '{10'($urandom_range(8)), 8'($urandom_range(4)), 10'($urandom_range(6)),
            8'($urandom_range(6)), 4'($urandom_range(3))};
      program_timing(c);
      phase_reqs = 0;
      while (phase_reqs < 40) begin
        k = kind_e'($urandom_range(1, 3));
        n = busy_ticks(k);
        // now and then cut a command short so the next one lands while busy
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        else n += $urandom_range(2);
        queue_req(k, 1'($urandom_range(1)), 8'($urandom_range(255)));
        queue_ticks(n, LINE_RANDOM, 1'b1);
        phase_reqs += n + 1;
      end
      drain();
    end

    set_idling(3);
    program_timing('{10'd1023, 8'd255, 10'd1023, 8'd1, 4'd15});
    queue_command(KIND_WRITE, 8'($urandom_range(255)), LINE_RANDOM);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/owbm_pkg.sv
rtl/owbm_ifs.sv
rtl/owbm_cfg_regs.sv
rtl/owbm_engine.sv
rtl/one_wire_bus_master_top.sv
tb/sv/one_wire_bus_master_top_tb.sv
